// ----- rtl/light_sensor_calibration_sequencer_unit_macros.svh -----
`ifndef LIGHT_SENSOR_CALIBRATION_SEQUENCER_UNIT_MACROS_SVH
`define LIGHT_SENSOR_CALIBRATION_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LSCS_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lscs: invariant violated");
`define LSCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lscs: implication violated");
`define LSCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lscs: next-cycle check violated");
`else
`define LSCS_ASSERT_ALWAYS(label, clk, rst, prop)
`define LSCS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/lscs_pkg.sv -----
package lscs_pkg;

   localparam int SAMPLE_WINDOW = 20;
   localparam int NLOG          = $clog2(SAMPLE_WINDOW);
   localparam int ADDR_W        = NLOG;
   localparam int CNT_W         = $clog2(SAMPLE_WINDOW + 1);
   localparam int SAMPLE_W      = 16;
   localparam int SUM_W         = SAMPLE_W + NLOG;
   localparam int SQ_W          = 2 * SAMPLE_W + NLOG;
   localparam int CMP_W         = 2 * SUM_W;
   localparam int WIN_SQ        = SAMPLE_WINDOW * SAMPLE_WINDOW;

   // floor(sum / N) as (sum * MEAN_MUL) >> MEAN_SHIFT, exact for sum < 2**SUM_W
   localparam int MEAN_SHIFT    = SUM_W + NLOG;
   localparam int MUL_W         = SUM_W + 1;
   localparam int MEAN_MUL      = ((2 ** MEAN_SHIFT) + SAMPLE_WINDOW - 1) / SAMPLE_WINDOW;

   localparam int REQ_DATA_W    = 16;
   localparam int RSP_FIELDS_W  = 54;
   localparam int RSP_DATA_W    = 56;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELDS_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [2:0] STEP_DARK    = 3'd0;
   localparam logic [2:0] STEP_BRIGHT  = 3'd1;
   localparam logic [2:0] STEP_DARK2   = 3'd2;
   localparam logic [2:0] STEP_BRIGHT2 = 3'd3;
   localparam logic [2:0] STEP_DONE    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_STAB_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SWING    = 2'd2;

   localparam logic [15:0] STAB_LIMIT_RST   = 16'd100;
   localparam logic [7:0]  STABLE_TICKS_RST = 8'd20;
   localparam logic [15:0] MIN_SWING_RST    = 16'd100;
   localparam logic [15:0] DARK_RESET       = 16'hFFFF;

   typedef struct packed {
      logic                done;
      logic                stable;
      logic [SAMPLE_W-1:0] mean;
   } lscs_stat_type;

endpackage

// ----- rtl/light_sensor_calibration_sequencer_unit.sv -----
// Response: a restart, an item after completion or a sample into a ring not yet full goes
// to ST_EMIT, which registers rsp_tvalid once any earlier response is taken; a sample that
// fills the window first waits in ST_STATS for the walk of the sample memory (one read per cycle).
// Flow: one item at a time; req_tready is high only in ST_IDLE, entered as the result is registered.
// Reset: synchronous, active high; step dark, counters cleared, range 65535/0, registers
// to defaults. The sample memory is not cleared.
`include "light_sensor_calibration_sequencer_unit_macros.svh"

module light_sensor_calibration_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lscs_pkg::REQ_DATA_W-1:0]     req_tdata,   // [15:0] light_sample
   input  logic                                req_tuser,   // [0] opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] step_now, [3] step_advanced, [19:4] settled_value, [20] all_done,
   // [21] succeeded, [37:22] range_low, [53:38] range_high
   output logic [lscs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [lscs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lscs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lscs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STATS = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            step_ff, step_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [7:0]            run_ff, run_in;
   logic [15:0]           min_ff, min_in;
   logic [15:0]           max_ff, max_in;
   logic                  adv_ff, adv_in;
   logic [15:0]           settled_ff, settled_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [15:0]           limit_ff;
   logic [7:0]            ticks_ff;
   logic [15:0]           swing_ff;

   logic                  req_fire;
   logic                  wr_en, start, rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SAMPLE_W-1:0]   rd_data;
   lscs_stat_type         stat;
   logic [7:0]            run_next, need;
   logic                  done, ok;

   lscs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SAMPLE_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (req_tdata[SAMPLE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lscs_win_stats u_stats (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .limit   (limit_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign run_next = (run_ff == 8'hFF) ? run_ff : run_ff + 8'd1;
   assign need     = (ticks_ff == 8'd0) ? 8'd1 : ticks_ff;
   assign done     = (step_ff >= STEP_DONE);
   assign ok       = done && (min_ff < max_ff) && ((max_ff - min_ff) > swing_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      run_in       = run_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      adv_in       = adv_ff;
      settled_in   = settled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      start        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               adv_in     = 1'b0;
               settled_in = '0;
               priority if (req_tuser == OP_RESTART) begin
                  step_in  = STEP_DARK;
                  slot_in  = '0;
                  fill_in  = '0;
                  run_in   = '0;
                  min_in   = DARK_RESET;
                  max_in   = '0;
                  state_in = ST_EMIT;
               end else if (step_ff >= STEP_DONE) begin
                  state_in = ST_EMIT;
               end else begin
                  wr_en   = 1'b1;
                  slot_in = (slot_ff == ADDR_W'(SAMPLE_WINDOW - 1)) ? '0 : slot_ff + 1'b1;
                  if (fill_ff < CNT_W'(SAMPLE_WINDOW)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (fill_ff >= CNT_W'(SAMPLE_WINDOW - 1)) begin
                     start    = 1'b1;
                     state_in = ST_STATS;
                  end else begin
                     run_in   = '0;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_STATS: begin
            if (stat.done) begin
               state_in = ST_EMIT;
               if (!stat.stable) begin
                  run_in = '0;
               end else if (run_next >= need) begin
                  if (step_ff == STEP_DARK || step_ff == STEP_DARK2) begin
                     if (stat.mean < min_ff) min_in = stat.mean;
                  end else begin
                     if (stat.mean > max_ff) max_in = stat.mean;
                  end
                  step_in    = step_ff + 3'd1;
                  run_in     = '0;
                  fill_in    = '0;
                  slot_in    = '0;
                  adv_in     = 1'b1;
                  settled_in = stat.mean;
               end else begin
                  run_in = run_next;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, max_ff, min_ff, ok, done,
                               settled_ff, adv_ff, step_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_DARK;
         slot_ff      <= '0;
         fill_ff      <= '0;
         run_ff       <= '0;
         min_ff       <= DARK_RESET;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         run_ff       <= run_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adv_ff      <= adv_in;
      settled_ff  <= settled_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= STAB_LIMIT_RST;
         ticks_ff <= STABLE_TICKS_RST;
         swing_ff <= MIN_SWING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STAB_LIMIT:   limit_ff <= csr_wdata;
            CSR_STABLE_TICKS: ticks_ff <= csr_wdata[7:0];
            CSR_MIN_SWING:    swing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   `LSCS_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(SAMPLE_WINDOW))
   `LSCS_ASSERT_ALWAYS(a_step_bound, clock, reset, step_ff <= STEP_DONE)
   `LSCS_ASSERT_IMPLY(a_stat_in_sweep, clock, reset, stat.done, state_ff == ST_STATS)
   `LSCS_ASSERT_NEXT(a_sweep_start, clock, reset, start, state_ff == ST_STATS)

endmodule

// ----- rtl/lscs_ram.sv -----
module lscs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lscs_win_stats.sv -----
module lscs_win_stats (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [15:0]                     limit,
   output logic                            rd_en,
   output logic [lscs_pkg::ADDR_W-1:0]     rd_addr,
   input  logic [lscs_pkg::SAMPLE_W-1:0]   rd_data,
   output lscs_pkg::lscs_stat_type         stat
);
   import lscs_pkg::*;

   logic                     issue_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic                     rd_vld_ff, rd_last_ff;
   logic                     sq_vld_ff, sq_last_ff;
   logic [SAMPLE_W-1:0]      x_ff;
   logic [2*SAMPLE_W-1:0]    sq_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SQ_W-1:0]          sumsq_ff;
   logic                     acc_done_ff;
   logic                     a_vld_ff, b_vld_ff;
   logic [CMP_W-1:0]         nsq_ff, sum2_ff, lim2n_ff;
   logic [31:0]              lim2_ff;
   logic [SUM_W+MUL_W-1:0]   mprod_ff;
   logic [CMP_W:0]           rhs;
   logic                     last_addr;
   logic                     stat_done_ff, stable_ff;
   logic [SAMPLE_W-1:0]      mean_ff;

   assign last_addr = (addr_ff == ADDR_W'(SAMPLE_WINDOW - 1));
   assign rd_en     = issue_ff;
   assign rd_addr   = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         sq_vld_ff    <= 1'b0;
         sq_last_ff   <= 1'b0;
         acc_done_ff  <= 1'b0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         stat_done_ff <= 1'b0;
      end else begin
         if (start) begin
            issue_ff <= 1'b1;
            addr_ff  <= '0;
         end else if (issue_ff) begin
            issue_ff <= !last_addr;
            addr_ff  <= addr_ff + 1'b1;
         end
         rd_vld_ff    <= issue_ff;
         rd_last_ff   <= issue_ff && last_addr;
         sq_vld_ff    <= rd_vld_ff;
         sq_last_ff   <= rd_vld_ff && rd_last_ff;
         acc_done_ff  <= sq_vld_ff && sq_last_ff;
         a_vld_ff     <= acc_done_ff;
         b_vld_ff     <= a_vld_ff;
         stat_done_ff <= b_vld_ff;
      end
   end

   // square, accumulate, then the variance and mean arithmetic
   always_ff @(posedge clock) begin
      x_ff  <= rd_data;
      sq_ff <= (2 * SAMPLE_W)'(rd_data) * (2 * SAMPLE_W)'(rd_data);
      if (start) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (sq_vld_ff) begin
         sum_ff   <= sum_ff + SUM_W'(x_ff);
         sumsq_ff <= sumsq_ff + SQ_W'(sq_ff);
      end
      if (acc_done_ff) begin
         nsq_ff   <= CMP_W'(sumsq_ff) * CMP_W'(SAMPLE_WINDOW);
         sum2_ff  <= CMP_W'(sum_ff) * CMP_W'(sum_ff);
         lim2_ff  <= 32'(limit) * 32'(limit);
         mprod_ff <= (SUM_W + MUL_W)'(sum_ff) * (SUM_W + MUL_W)'(MEAN_MUL);
      end
      if (a_vld_ff) begin
         lim2n_ff <= CMP_W'(lim2_ff) * CMP_W'(WIN_SQ);
      end
      if (b_vld_ff) begin
         stable_ff <= ({1'b0, nsq_ff} < rhs);
         mean_ff   <= mprod_ff[MEAN_SHIFT +: SAMPLE_W];
      end
   end

   assign rhs  = {1'b0, lim2n_ff} + {1'b0, sum2_ff};
   assign stat = '{done: stat_done_ff, stable: stable_ff, mean: mean_ff};

endmodule
